// ===== rtl/assert_macros.svh =====
// Assertion helper macros shared by the reach table RTL.
// No dependencies; included by modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Combinational property that must hold at every edge outside reset.
`define BRT_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("reach table check failed");
// Same-cycle implication.
`define BRT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("reach table implication failed");
// Next-cycle implication.
`define BRT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("reach table sequence failed");
`endif

// ===== rtl/brt_pkg.sv =====
// Shared types and constants of the bitset reach table.
// No dependencies.
`default_nettype none
package brt_pkg;

  typedef enum logic [1:0] {
    CMD_GAIN   = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_SETQ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_t;

  localparam logic        REG_DENSE = 1'b0;
  localparam logic        REG_LIMIT = 1'b1;
  localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;
  localparam int          HASH_SHIFT = 7;
  localparam logic [7:0]  UNREACHED = 8'hFF;

  // One queued command, classified by the front end.
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] node;
    logic [63:0] word;
    logic [7:0]  hop;
    logic        flag;
    logic [5:0]  tbit;
    logic [15:0] home;      // hash home slot, low bits used
    logic        dense;
    logic        in_range;  // dense only: node below effective limit
  } brt_item_t;

  // One table row.
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [63:0] reach;
    logic [7:0]  first;
    logic        queued;
  } brt_row_t;

  typedef struct packed {
    logic clearing;
  } brt_stat_t;

endpackage
`default_nettype wire

// ===== rtl/brt_front.sv =====
// Front end: accepts command beats, hashes and classifies them, 2-deep queue.
// Depends on brt_pkg.
`default_nettype none
module brt_front #(
  parameter int TABLE_SLOTS = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        cmd,
  input  wire logic [31:0]       node,
  input  wire logic [63:0]       word,
  input  wire logic [7:0]        hop_distance,
  input  wire logic              flag_value,
  input  wire logic [5:0]        target_bit,
  input  wire logic              dense_mode,
  input  wire logic [10:0]       node_limit,
  input  wire brt_pkg::brt_stat_t stat,
  output logic                   q_valid,
  output brt_pkg::brt_item_t     q_item,
  input  wire logic              q_pop
);
  import brt_pkg::*;

  localparam int SB = $clog2(TABLE_SLOTS);

  brt_item_t  ent [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] q_count;
  brt_item_t  new_item;
  logic [63:0] product;
  logic        push;

  assign product = 64'(node) * 64'(HASH_MULT);

  always_comb begin
    new_item          = '0;
    new_item.cmd      = cmd_t'(cmd);
    new_item.node     = node;
    new_item.word     = word;
    new_item.hop      = hop_distance;
    new_item.flag     = flag_value;
    new_item.tbit     = target_bit;
    new_item.home     = 16'(product[HASH_SHIFT+SB-1:HASH_SHIFT]);
    new_item.dense    = dense_mode;
    new_item.in_range = (node < 32'(node_limit)) && (node < 32'(TABLE_SLOTS));
  end

  assign in_ready = (q_count != 2'd2) && !stat.clearing;
  assign push     = in_valid && in_ready;
  assign q_valid  = (q_count != 2'd0);
  assign q_item   = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
      q_count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      q_count <= q_count + 2'(push) - 2'(q_pop);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/brt_back.sv =====
// Back end: table memories, probe sequencer, clearing sweep, result register.
// Depends on brt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module brt_back #(
  parameter int TABLE_SLOTS = 1024,
  parameter int TARGET_BITS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_clear,
  input  wire logic               dense_mode,
  input  wire logic               q_valid,
  input  wire brt_pkg::brt_item_t q_item,
  output logic                    q_pop,
  output brt_pkg::brt_stat_t      stat,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [63:0]             gained,
  output logic [63:0]             reached_word,
  output logic                    is_queued,
  output logic [7:0]              min_hops,
  output logic [7:0]              target_hops,
  output logic [10:0]             entries_used,
  output logic [1:0]              status
);
  import brt_pkg::*;

  localparam int SB  = $clog2(TABLE_SLOTS);
  localparam int CW  = $clog2(TABLE_SLOTS + 1);
  localparam int TIW = (TARGET_BITS > 1) ? $clog2(TARGET_BITS) : 1;
  localparam logic [63:0] WMASK = 64'((65'(1) << TARGET_BITS) - 65'(1));
  localparam logic [CW-1:0] HALF = CW'(TABLE_SLOTS / 2);

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_CHECK, S_CLEAR} state_t;

  state_t        state;
  brt_item_t     cur;
  logic [SB-1:0] slot;
  logic [SB-1:0] clr_idx;
  logic [CW-1:0] used;

  brt_row_t   row_mem  [TABLE_SLOTS];
  logic [7:0] dist_mem [TABLE_SLOTS][TARGET_BITS];
  brt_row_t   row_q;
  logic [7:0] dist_q [TARGET_BITS];

  logic out_free;
  logic hit, empty, full, settle, ok, insert, count_up, do_write;
  logic res_load;
  logic [63:0] gain_bits, gained_c, reach_new;
  logic [7:0]  first_new, th;
  logic        queued_new;
  logic [TIW-1:0] lane;

  logic                   wr_en;
  logic [SB-1:0]          wr_addr;
  brt_row_t               wr_row;
  logic [7:0]             wr_dist;
  logic [TARGET_BITS-1:0] wr_lane;

  assign out_free = !out_valid || out_ready;
  assign stat.clearing = (state == S_CLEAR);

  // Memory read, registered; address is the probe slot.
  always_ff @(posedge clk) begin
    row_q  <= row_mem[slot];
    dist_q <= dist_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_mem[wr_addr] <= wr_row;
      for (int l = 0; l < TARGET_BITS; l++) begin
        if (wr_lane[l]) dist_mem[wr_addr][l] <= wr_dist;
      end
    end
  end

  always_comb begin
    hit        = row_q.valid && (row_q.key == cur.node);
    empty      = !row_q.valid;
    full       = (used >= HALF);
    settle     = cur.dense || hit || empty;
    insert     = !cur.dense && empty && (cur.cmd == CMD_GAIN) && !full;
    ok         = cur.dense || hit || insert;
    gain_bits  = (cur.cmd == CMD_GAIN) ? (cur.word & WMASK) : 64'd0;
    gained_c   = gain_bits & ~row_q.reach;
    reach_new  = row_q.reach | gained_c;
    first_new  = ((row_q.reach == 64'd0) && (gained_c != 64'd0)) ? cur.hop : row_q.first;
    queued_new = (cur.cmd == CMD_SETQ) ? cur.flag : row_q.queued;
    lane       = TIW'(cur.tbit);
    if (32'(cur.tbit) < 32'(TARGET_BITS)) begin
      th = gained_c[cur.tbit] ? cur.hop : dist_q[lane];
    end else begin
      th = UNREACHED;
    end
    count_up = insert ||
               (cur.dense && (gained_c != 64'd0) && (row_q.reach == 64'd0));
    do_write = (state == S_CHECK) && settle && ok && out_free && (cur.cmd != CMD_LOOKUP);
    // Result register loads: immediate answers at pop, or a settled probe.
    res_load = !cfg_clear &&
               ((q_pop && ((q_item.cmd == CMD_CLEAR) ||
                           (q_item.dense && !q_item.in_range))) ||
                ((state == S_CHECK) && settle && out_free));
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot;
    wr_row  = row_q;
    wr_dist = cur.hop;
    wr_lane = '0;
    if (state == S_CLEAR) begin
      wr_en        = 1'b1;
      wr_addr      = clr_idx;
      wr_row       = '0;
      wr_row.first = UNREACHED;
      wr_dist      = UNREACHED;
      wr_lane      = '1;
    end else if (do_write) begin
      wr_en         = 1'b1;
      wr_row.reach  = reach_new;
      wr_row.first  = cur.dense ? row_q.first : first_new;
      wr_row.queued = queued_new;
      if (!cur.dense) begin
        wr_row.valid = 1'b1;
        wr_row.key   = cur.node;
        wr_lane      = gained_c[TARGET_BITS-1:0];
      end
    end
  end

  assign q_pop = (state == S_IDLE) && q_valid && out_free && !cfg_clear;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (res_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cfg_clear) begin
        state   <= S_CLEAR;
        clr_idx <= '0;
        used    <= '0;
      end else begin
        unique case (state)
          S_IDLE: begin
            if (q_pop) begin
              if (q_item.cmd == CMD_CLEAR) begin
                gained       <= '0;
                reached_word <= '0;
                is_queued    <= 1'b0;
                min_hops     <= UNREACHED;
                target_hops  <= UNREACHED;
                entries_used <= '0;
                status       <= ST_OK;
                used         <= '0;
                clr_idx      <= '0;
                state        <= S_CLEAR;
              end else if (q_item.dense && !q_item.in_range) begin
                gained       <= '0;
                reached_word <= '0;
                is_queued    <= 1'b0;
                min_hops     <= UNREACHED;
                target_hops  <= UNREACHED;
                entries_used <= 11'(used);
                status       <= ST_ABSENT;
              end else begin
                cur   <= q_item;
                slot  <= q_item.dense ? SB'(q_item.node) : SB'(q_item.home);
                state <= S_LOOK;
              end
            end
          end
          S_LOOK: state <= S_CHECK;
          S_CHECK: begin
            if (!settle) begin
              slot  <= slot + SB'(1);
              state <= S_LOOK;
            end else if (out_free) begin
              entries_used <= 11'(used + CW'(count_up));
              used         <= used + CW'(count_up);
              if (ok) begin
                gained       <= gained_c;
                reached_word <= reach_new;
                is_queued    <= queued_new;
                min_hops     <= cur.dense ? UNREACHED : first_new;
                target_hops  <= cur.dense ? UNREACHED : th;
                status       <= ST_OK;
              end else begin
                gained       <= '0;
                reached_word <= '0;
                is_queued    <= 1'b0;
                min_hops     <= UNREACHED;
                target_hops  <= UNREACHED;
                status       <= (cur.cmd == CMD_GAIN) ? ST_FULL : ST_ABSENT;
              end
              state <= S_IDLE;
            end
          end
          S_CLEAR: begin
            clr_idx <= clr_idx + SB'(1);
            if (clr_idx == {SB{1'b1}}) state <= S_IDLE;
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  `BRT_ASSERT_IMP(a_half_full, clk, rst, !dense_mode && (state != S_CLEAR), used <= HALF)
  `BRT_ASSERT_NXT(a_cfg_sweep, clk, rst, cfg_clear, state == S_CLEAR && clr_idx == '0)
  `BRT_ASSERT_IMP(a_absent_vals, clk, rst, out_valid && (status == ST_ABSENT),
                  reached_word == 64'd0 && min_hops == UNREACHED && gained == 64'd0)

endmodule
`default_nettype wire

// ===== rtl/bitset_reach_table_unit.sv =====
// Top level of the bitset reach table: config registers, front end, back end.
// Depends on brt_pkg, brt_front, brt_back.
//
// Usage:
//  - Command channel (in_valid/in_ready) carries cmd, node, word, hop_distance,
//    flag_value and target_bit; one result beat per command on the result
//    channel (out_valid/out_ready), in command order.
//  - Config port: cfg_we with cfg_index 0 = dense_mode, 1 = node_limit. Any
//    write empties the store; write only while the block is idle.
//  - Sequencing: a sparse command passes through S_LOOK and S_CHECK once per
//    probe slot walked (memory read is registered). Dense commands make
//    one S_LOOK/S_CHECK pass; clear and out-of-range commands answer at pop.
//  - The sequencer takes no new command from the queue until the current
//    sparse or dense command has settled and its result is loaded.
//  - A 2-beat queue sits in front of the sequencer, so commands are taken
//    while a result waits in the output register.
//  - Reset, clear commands and config writes start a sweep of every row
//    (one row per cycle) during which in_ready is low.
//  - When the receiver stalls, the result holds, the sequencer stops at its
//    last step and the queue fills, then in_ready drops.
//  - TABLE_SLOTS must be a power of two (hash home is a bit field).
`default_nettype none
module bitset_reach_table_unit #(
  parameter int TABLE_SLOTS = 1024,
  parameter int TARGET_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [10:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] node,
  input  wire logic [63:0] word,
  input  wire logic [7:0]  hop_distance,
  input  wire logic        flag_value,
  input  wire logic [5:0]  target_bit,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      gained,
  output logic [63:0]      reached_word,
  output logic             is_queued,
  output logic [7:0]       min_hops,
  output logic [7:0]       target_hops,
  output logic [10:0]      entries_used,
  output logic [1:0]       status
);
  import brt_pkg::*;

  logic        dense_mode;
  logic [10:0] node_limit;
  logic        q_valid, q_pop;
  brt_item_t   q_item;
  brt_stat_t   stat;

  // Config registers; every write also triggers the clearing sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      dense_mode <= 1'b0;
      node_limit <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_DENSE) dense_mode <= cfg_data[0];
      if (cfg_index == REG_LIMIT) node_limit <= cfg_data;
    end
  end

  brt_front #(.TABLE_SLOTS(TABLE_SLOTS)) u_front (
    .clk, .rst, .in_valid, .in_ready, .cmd, .node, .word, .hop_distance,
    .flag_value, .target_bit, .dense_mode, .node_limit, .stat,
    .q_valid, .q_item, .q_pop
  );

  brt_back #(.TABLE_SLOTS(TABLE_SLOTS), .TARGET_BITS(TARGET_BITS)) u_back (
    .clk, .rst, .cfg_clear(cfg_we), .dense_mode, .q_valid, .q_item, .q_pop,
    .stat, .out_valid, .out_ready, .gained, .reached_word, .is_queued,
    .min_hops, .target_hops, .entries_used, .status
  );

endmodule
`default_nettype wire
